@@ hw/rtl/lgrs_pkg.sv @@
// Package for the look-ahead gain ramp smoother: sizes, constants, shared types.
// No dependencies.
package lgrs_pkg;
  localparam int MAX_BLOCK_C  = 64;
  localparam int MAX_DELAY_C  = 1024;
  localparam int RING_DEPTH_C = 1088;
  localparam int DELAY_W      = 11;
  localparam int GAIN_W       = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 11'd64;
  localparam logic [0:0] REG_DELAY = 1'b0;

  // block handed from front to back
  typedef struct packed {
    logic [12:0] end_ptr;   // ring position after the newest entry
    logic [6:0]  count;     // samples in block
  } blk_t;
endpackage

@@ hw/rtl/lgrs_div.sv @@
// Restoring divider: |num| (40 bit) / den (11 bit), one quotient bit per cycle.
// Uses lgrs_pkg.
module lgrs_div
  import lgrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [39:0]        num,
  input  logic [DELAY_W-1:0] den,
  output logic               done,
  output logic [39:0]        quo
);
  logic [39:0] q_r, q_nxt;
  logic [DELAY_W:0] rem_r, rem_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [DELAY_W+1:0] trial;

  assign trial = {rem_r, q_r[39]};
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done = 1'b0;
    if (go) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = 6'd40; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, den}) begin
        rem_nxt = (DELAY_W+1)'(trial - {2'b00, den});
        q_nxt = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = trial[DELAY_W:0];
        q_nxt = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done = 1'b1;
      end
    end
  end
  assign quo = q_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
  end
endmodule

@@ hw/rtl/lgrs_front.sv @@
// Front end: writes samples to the ring port, counts the block, queues finished blocks.
// Uses lgrs_pkg.
module lgrs_front
  import lgrs_pkg::*;
#(
  parameter int MAX_BLOCK  = MAX_BLOCK_C,
  parameter int RING_DEPTH = RING_DEPTH_C
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic        block_end,
  output logic        wr_en,
  output logic [12:0] wr_addr,
  output logic        q_full,
  output logic        q_valid,
  output blk_t        q_head,
  input  logic        q_pop
);
  logic [12:0] wp_r, wp_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  blk_t q0_r, q1_r;
  logic [1:0] n_r, n_nxt;
  logic fin;
  logic to_head;

  assign wr_en = take;
  assign wr_addr = wp_r;
  assign wp_nxt = (wp_r == 13'(RING_DEPTH - 1)) ? 13'd0 : wp_r + 13'd1;
  assign cnt_nxt = cnt_r + 7'd1;
  assign fin = take && (block_end || cnt_nxt >= 7'(MAX_BLOCK));
  assign to_head = n_r == 2'd0 || (n_r == 2'd1 && q_pop);
  assign q_full = n_r[1];
  assign q_valid = n_r != 2'd0;
  assign q_head = q0_r;
  always_comb begin
    n_nxt = n_r;
    if (fin && !q_pop) n_nxt = n_r + 2'd1;
    else if (!fin && q_pop) n_nxt = n_r - 2'd1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; cnt_r <= '0; n_r <= '0;
    end else begin
      n_r <= n_nxt;
      if (take) begin
        wp_r <= wp_nxt;
        cnt_r <= fin ? 7'd0 : cnt_nxt;
      end
    end
    if (fin && to_head) q0_r <= '{end_ptr: wp_nxt, count: cnt_nxt};
    else if (q_pop) q0_r <= q1_r;
    if (fin && !to_head) q1_r <= '{end_ptr: wp_nxt, count: cnt_nxt};
  end
endmodule

@@ hw/rtl/lgrs_back.sv @@
// Back end: owns the ring memory, walks a block backwards applying the ramp,
// then streams the delayed block out. Uses lgrs_pkg and lgrs_div.
module lgrs_back
  import lgrs_pkg::*;
#(
  parameter int MAX_DELAY  = MAX_DELAY_C,
  parameter int RING_DEPTH = RING_DEPTH_C
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DELAY_W-1:0] delay,
  input  logic               wr_en,
  input  logic [12:0]        wr_addr,
  input  logic [GAIN_W-1:0]  wr_data,
  input  logic               q_valid,
  input  blk_t               q_head,
  output logic               q_pop,
  output logic               back_idle,
  output logic               out_valid,
  output logic [GAIN_W-1:0]  out_data,
  output logic               out_last
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_WT = 4'd3,
    S_CMP = 4'd4, S_DIV = 4'd5, S_OUT0 = 4'd6, S_OUT1 = 4'd7, S_OUT2 = 4'd8;
  localparam int AW = $clog2(RING_DEPTH);
  // multiple of the depth that covers the largest block plus delay
  localparam int OFFS = ((127 + MAX_DELAY) / RING_DEPTH + 1) * RING_DEPTH;

  logic [GAIN_W-1:0] mem [RING_DEPTH];
  logic [GAIN_W-1:0] rdata_r;
  logic [3:0] st_r, st_nxt;
  logic [12:0] pos_r, pos_nxt, clr_r, end_r;
  logic [6:0] n_r, i_r;
  logic [10:0] k_r;
  logic tail_r;
  logic signed [40:0] ramp_r, slope_r;
  logic [DELAY_W-1:0] d_r;
  logic [12:0] addr;
  logic mw_en;
  logic [GAIN_W-1:0] mw_data;
  logic signed [40:0] s;
  logic signed [40:0] fl;
  logic [GAIN_W-1:0] sat;
  logic div_go, div_done;
  logic [39:0] div_q;
  logic neg_r;
  logic [13:0] back_sum, acc_r;

  function automatic logic [12:0] dec(input logic [12:0] p);
    dec = (p == 13'd0) ? 13'(RING_DEPTH - 1) : p - 13'd1;
  endfunction
  function automatic logic [12:0] inc(input logic [12:0] p);
    inc = (p == 13'(RING_DEPTH - 1)) ? 13'd0 : p + 13'd1;
  endfunction

  lgrs_div u_div (.clk, .rst_n, .go(div_go), .num((s < 0) ? 40'(-s) : 40'(s)),
    .den(d_r), .done(div_done), .quo(div_q));

  assign s = 41'(signed'(rdata_r)) <<< 16;
  assign fl = ramp_r >>> 16;
  assign sat = (fl > 41'sd32767) ? 16'h7fff : (fl < -41'sd32768) ? 16'h8000 : fl[15:0];
  assign back_idle = st_r == S_IDLE;
  assign q_pop = st_r == S_IDLE && q_valid;
  // start of read: end - n - d, brought into range by subtracting the depth in S_OUT0
  assign back_sum = {1'b0, end_r} + 14'(OFFS) - 14'(n_r) - 14'(d_r);

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; div_go = 1'b0;
    mw_en = 1'b0; mw_data = '0; addr = pos_r;
    unique case (st_r)
      S_CLR: begin
        mw_en = 1'b1; addr = clr_r;
        if (clr_r == 13'(RING_DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        pos_nxt = dec(q_head.end_ptr);
        if (q_valid) st_nxt = S_RD;
      end
      S_RD: st_nxt = S_WT;
      S_WT: st_nxt = S_CMP;
      S_CMP: begin
        if (s > ramp_r) begin
          mw_en = 1'b1; mw_data = sat;
          pos_nxt = dec(pos_r);
          if (tail_r && k_r + 11'd1 == 11'(d_r))
            st_nxt = S_OUT0;
          else st_nxt = S_RD;
        end else if (tail_r) begin
          st_nxt = S_OUT0;
        end else begin
          div_go = 1'b1; st_nxt = S_DIV;
        end
      end
      S_DIV: if (div_done) begin
        pos_nxt = dec(pos_r);
        st_nxt = (i_r + 7'd1 == n_r && d_r == 11'd0) ? S_OUT0 : S_RD;
      end
      S_OUT0: if (acc_r < 14'(RING_DEPTH)) begin
        pos_nxt = acc_r[12:0];
        st_nxt = S_OUT1;
      end
      S_OUT1: begin
        pos_nxt = inc(pos_r);
        st_nxt = S_OUT2;
      end
      S_OUT2: st_nxt = (i_r + 7'd1 == n_r) ? S_IDLE : S_OUT1;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    else if (mw_en) mem[addr[AW-1:0]] <= mw_data;
    rdata_r <= mem[addr[AW-1:0]];
  end

  assign out_valid = st_r == S_OUT2;
  assign out_data = rdata_r;
  assign out_last = i_r + 7'd1 == n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 13'd1;
    end
    pos_r <= pos_nxt;
    if (st_r == S_IDLE) begin
      d_r <= (delay == '0) ? 11'd1 : (delay > 11'(MAX_DELAY)) ? 11'(MAX_DELAY) : delay;
      n_r <= q_head.count; end_r <= q_head.end_ptr;
      i_r <= '0; k_r <= '0; tail_r <= 1'b0; ramp_r <= '0; slope_r <= '0;
    end
    if (st_r == S_CMP) neg_r <= s > 0;
    if (st_r == S_CMP && s > ramp_r) begin
      ramp_r <= ramp_r + slope_r;
      if (tail_r) k_r <= k_r + 11'd1;
      else if (i_r + 7'd1 == n_r) tail_r <= 1'b1;
      else i_r <= i_r + 7'd1;
    end
    if (st_r == S_DIV && div_done) begin
      slope_r <= neg_r ? -41'(signed'({1'b0, div_q})) : 41'(signed'({1'b0, div_q}));
      ramp_r <= s + (neg_r ? -41'(signed'({1'b0, div_q})) : 41'(signed'({1'b0, div_q})));
      if (i_r + 7'd1 == n_r) tail_r <= 1'b1;
      else i_r <= i_r + 7'd1;
    end
    if (st_nxt == S_OUT0 && st_r != S_OUT0) begin
      // rewind to read start
      acc_r <= back_sum;
      i_r <= '0;
    end
    if (st_r == S_OUT0 && acc_r >= 14'(RING_DEPTH)) acc_r <= acc_r - 14'(RING_DEPTH);
    if (st_r == S_OUT2 && st_nxt == S_OUT1) i_r <= i_r + 7'd1;
  end
endmodule

@@ hw/rtl/lookahead_gain_ramp_smoother_core.sv @@
// Look-ahead gain ramp smoother, top level. Uses lgrs_pkg, lgrs_front, lgrs_back.
// Flow: a sample is taken while start is high and busy is low; from the last sample of a
// block busy stays high until that block has been emitted. After the last sample the block
// is handed over, the back walks n plus up to d entries and runs the serial divider once per
// dip, rewinds to the read start, then emits the block's values in order.
// Reset: synchronous; the ring is then cleared entry by entry with busy high.
module lookahead_gain_ramp_smoother_core
  import lgrs_pkg::*;
#(
  parameter int MAX_BLOCK  = MAX_BLOCK_C,
  parameter int MAX_DELAY  = MAX_DELAY_C,
  parameter int RING_DEPTH = RING_DEPTH_C
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       in_gain_db,
  input  logic              in_block_end,
  output logic              out_strobe,
  output logic [15:0]       out_smoothed_gain_db,
  output logic              out_last_of_run,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [0:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [DELAY_W-1:0] delay_r;
  logic take, wr_en, q_full, q_valid, q_pop, back_idle;
  logic [12:0] wr_addr;
  blk_t q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DELAY) ? {21'd0, delay_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) delay_r <= DELAY_RESET;
    else if (psel && penable && pwrite && paddr == REG_DELAY) delay_r <= pwdata[10:0];
  end

  // the next block's writes would land on ring entries the back still needs
  assign busy = q_full || q_valid || !back_idle;
  assign take = start && !busy;

  lgrs_front #(.MAX_BLOCK(MAX_BLOCK), .RING_DEPTH(RING_DEPTH)) u_front (
    .clk, .rst_n, .take, .block_end(in_block_end), .wr_en, .wr_addr,
    .q_full, .q_valid, .q_head, .q_pop);

  lgrs_back #(.MAX_DELAY(MAX_DELAY), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk, .rst_n, .delay(delay_r), .wr_en, .wr_addr, .wr_data(in_gain_db),
    .q_valid, .q_head, .q_pop, .back_idle, .out_valid(out_strobe),
    .out_data(out_smoothed_gain_db), .out_last(out_last_of_run));
endmodule

@@ verif/lookahead_gain_ramp_smoother_core_tb.sv @@
// Self-checking testbench for lookahead_gain_ramp_smoother_core.
// Depends on lgrs_pkg and the core RTL; it predicts each emitted value
// from its own copy of the gain ring and compares every strobed result.
module lookahead_gain_ramp_smoother_core_tb;
  import lgrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] gain;
    logic        last;
  } smoothed_t;

  class ramp_scoreboard;
    logic signed [15:0] ring[RING_DEPTH_C];
    int unsigned        wr_pos;
    int unsigned        blk_len;
    logic [10:0]        delay_reg;
    smoothed_t          pending_q[$];
    int                 mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos     = 0;
      blk_len    = 0;
      delay_reg  = DELAY_RESET;
      mismatches = 0;
    endfunction

    function void report(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatches++;
    endfunction

    function int unsigned back(int unsigned p, int unsigned amt);
      return (p + RING_DEPTH_C - (amt % RING_DEPTH_C)) % RING_DEPTH_C;
    endfunction

    // floor to Q8.8, then saturate
    function logic signed [15:0] to_q88(longint v);
      longint q;
      q = v >>> 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void set_delay(logic [31:0] v);
      delay_reg = v[10:0];
    endfunction

    function void note_sample(logic signed [15:0] g, logic blk_end);
      int unsigned n, d, p, rd;
      longint      ramp, slope, s;
      smoothed_t   item;
      ring[wr_pos] = g;
      wr_pos = (wr_pos + 1) % RING_DEPTH_C;
      blk_len++;
      if (!blk_end && blk_len < MAX_BLOCK_C) return;
      n = blk_len;
      d = delay_reg;
      if (d == 0) d = 1;
      if (d > MAX_DELAY_C) d = MAX_DELAY_C;
      ramp  = 0;
      slope = 0;
      p = back(wr_pos, 1);
      // walk the new block, then up to d older entries while above the ramp
      for (int unsigned i = 0; i < n + d; i++) begin
        s = longint'(ring[p]) * 65536;
        if (s > ramp) begin
          ring[p] = to_q88(ramp);
          ramp += slope;
        end else if (i < n) begin
          slope = -s / longint'(d);
          ramp  = s + slope;
        end else begin
          break;
        end
        p = back(p, 1);
      end
      rd = back(back(wr_pos, n), d);
      for (int unsigned k = 0; k < n; k++) begin
        item.gain = ring[rd];
        item.last = (k + 1 == n);
        pending_q.push_back(item);
        rd = (rd + 1) % RING_DEPTH_C;
      end
      blk_len = 0;
    endfunction

    function void check_result(logic [15:0] gain, logic last);
      smoothed_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result gain=%h last=%b", gain, last));
        return;
      end
      e = pending_q.pop_front();
      if (gain !== e.gain)
        report($sformatf("smoothed_gain_db %h, predicted %h", gain, e.gain));
      if (last !== e.last)
        report($sformatf("last_of_run %b, predicted %b", last, e.last));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [15:0] in_gain_db = '0;
  logic        in_block_end = 0;
  logic        out_strobe;
  logic [15:0] out_smoothed_gain_db;
  logic        out_last_of_run;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ramp_scoreboard sb = new();
  int          idle_pct = 0;
  int          sent = 0;

  lookahead_gain_ramp_smoother_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_gain_db(in_gain_db), .in_block_end(in_block_end),
    .out_strobe(out_strobe), .out_smoothed_gain_db(out_smoothed_gain_db),
    .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_smoothed_gain_db, out_last_of_run);
  end

  initial begin
    #100ms;
    $display("lookahead_gain_ramp_smoother_core regression: fail");
    $finish;
  end

  // one transaction; a sender gap may follow
  task automatic send_sample(logic [15:0] g, logic e);
    start        <= 1'b1;
    in_gain_db   <= g;
    in_block_end <= e;
    do @(posedge clk); while (busy);
    sb.note_sample(g, e);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_delay(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_DELAY;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_delay(v);
  endtask

  function automatic logic [15:0] rand_gain();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 16'(-$urandom_range(8000));
    if (r < 60) return 16'h0000;
    if (r < 70) return 16'($urandom_range(1, 2000));
    return 16'($urandom);
  endfunction

  // well-formed block; a 64-sample block sometimes ends without the marker
  task automatic send_block(int unsigned len);
    for (int unsigned i = 1; i <= len; i++)
      send_sample(rand_gain(),
                  (i == len) ? ((len == MAX_BLOCK_C) ? 1'($urandom_range(1)) : 1'b1) : 1'b0);
  endtask

  task automatic random_blocks(int unsigned budget, int unsigned maxlen);
    int unsigned stop, len;
    stop = sent + budget;
    while (sent < stop) begin
      len = ($urandom_range(9) == 0) ? maxlen : $urandom_range(1, maxlen);
      send_block(len);
    end
  endtask

  initial begin
    logic [15:0] directed[$];
    logic [31:0] delays[6];
    int          budgets[6];
    int          maxlens[6];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, leading positives, dips and recoveries at the reset delay
    directed = '{16'h7FFF, 16'h0064, 16'h8000, 16'h0000, 16'hFFFF, 16'hFC18,
                 16'h0000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0000};
    foreach (directed[i]) send_sample(directed[i], i == directed.size() - 1);
    send_sample(16'hEC78, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8001, 1'b1);
    drain();

    delays  = '{32'd1, 32'd1024, 32'd0, 32'd2047, 32'd5, 32'h0};
    budgets = '{70, 20, 60, 15, 60, 60};
    maxlens = '{64, 8, 64, 8, 64, 32};
    delays[5] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_delay(delays[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 35;
      endcase
      random_blocks(budgets[ph], maxlens[ph]);
      drain();
    end
    write_delay(32'd64);
    idle_pct = 20;
    random_blocks(20, 16);
    drain();
    repeat (100) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("lookahead_gain_ramp_smoother_core regression: pass");
    else
      $display("lookahead_gain_ramp_smoother_core regression: fail");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/lgrs_pkg.sv
hw/rtl/lgrs_div.sv
hw/rtl/lgrs_front.sv
hw/rtl/lgrs_back.sv
hw/rtl/lookahead_gain_ramp_smoother_core.sv
verif/lookahead_gain_ramp_smoother_core_tb.sv
